FILE: hdl/r2fft_pkg.sv
`default_nettype none
package r2fft_pkg;

  localparam int Points     = 64;
  localparam int SampleBits = 16;
  localparam int LogPoints  = $clog2(Points);
  localparam int AddrW      = 6;
  localparam int ValW       = 23;
  localparam int StageW     = 3;
  localparam int TwW        = 16;

  typedef logic signed [ValW-1:0] val_t;
  typedef logic [AddrW-1:0] addr_t;

  // one store entry, real and imaginary parts
  typedef struct packed {
    val_t re;
    val_t im;
  } cplx_t;

  // store access request from the sequencer
  typedef struct packed {
    logic  we_a;
    logic  we_b;
    addr_t addr_a;
    addr_t addr_b;
    cplx_t wdata_a;
    cplx_t wdata_b;
  } mem_req_t;

  // saturate a wide value to the store width
  function automatic val_t sat(input logic signed [47:0] v);
    logic signed [47:0] hi;
    logic signed [47:0] lo;
    hi = 48'sd4194303;
    lo = -48'sd4194304;
    if (v > hi) sat = val_t'(hi);
    else if (v < lo) sat = val_t'(lo);
    else sat = val_t'(v);
  endfunction

  // quarter-wave cosine in Q1.15, index 0..16
  function automatic logic signed [TwW-1:0] qcos(input logic [4:0] i);
    logic signed [TwW-1:0] r;
    case (i)
      5'd0: r = 16'sd32767;  5'd1: r = 16'sd32610;  5'd2: r = 16'sd32138;
      5'd3: r = 16'sd31357;  5'd4: r = 16'sd30274;  5'd5: r = 16'sd28899;
      5'd6: r = 16'sd27246;  5'd7: r = 16'sd25330;  5'd8: r = 16'sd23170;
      5'd9: r = 16'sd20788;  5'd10: r = 16'sd18205; 5'd11: r = 16'sd15447;
      5'd12: r = 16'sd12540; 5'd13: r = 16'sd9512;  5'd14: r = 16'sd6393;
      5'd15: r = 16'sd3212;  default: r = 16'sd0;
    endcase
    qcos = r;
  endfunction

  function automatic logic signed [TwW-1:0] tw_cos(input logic [4:0] i);
    if (i <= 5'd16) tw_cos = qcos(i);
    else tw_cos = -qcos(5'(6'd32 - {1'b0, i}));
  endfunction

  function automatic logic signed [TwW-1:0] tw_sin(input logic [4:0] i);
    if (i <= 5'd16) tw_sin = qcos(5'(5'd16 - i));
    else tw_sin = qcos(5'(i - 5'd16));
  endfunction

  // round to nearest, halves up, then shift by 15
  function automatic logic signed [24:0] rnd15(input logic signed [39:0] p);
    logic signed [39:0] t;
    t = p + 40'sd16384;
    rnd15 = 25'(t >>> 15);
  endfunction

endpackage
`default_nettype wire

FILE: hdl/radix2_fft_real_input.sv
// a frame's first bin appears only after its last sample is loaded and every
// butterfly stage has run; bins then follow in index order as out_ready takes them.
// throughput: one sample per cycle while loading; no new frame is taken until the last
// bin is sent; butterflies pass one at a time via the store (read, multiply, write).
// reset: synchronous active-low rst_n clears the sequencer and load count; the store
// is not cleared, every entry is written by the load before it is read.
`default_nettype none
module radix2_fft_real_input (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [15:0] in_sample,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [22:0]      out_bin_real,
  output logic [22:0]      out_bin_imag,
  output logic [5:0]       out_bin_index,
  output logic             out_last_bin
);

  typedef enum logic [2:0] {S_LOAD, S_RD, S_MUL, S_WR, S_GAP, S_EMIT} state_t;

  localparam int AW = r2fft_pkg::AddrW;

  state_t state_r;
  logic [AW:0] cnt_r;            // load count, or emit read count
  logic [r2fft_pkg::StageW-1:0] stg_r;
  logic [AW-2:0] bf_r;           // butterfly within stage
  logic [AW-1:0] ea_r, eb_r;
  logic [4:0] tw_r;
  logic pend_r;
  logic [AW-1:0] pidx_r;

  r2fft_pkg::mem_req_t req;
  r2fft_pkg::cplx_t rda, rdb, ya, yb;
  logic signed [15:0] tc, ts;

  r2fft_store u_store (.clk(clk), .req(req), .rdata_a(rda), .rdata_b(rdb));
  r2fft_bfly u_bfly (.clk(clk), .a(rda), .b(rdb), .c(tc), .s(ts), .ya(ya), .yb(yb));

  assign tc = r2fft_pkg::tw_cos(tw_r);
  assign ts = r2fft_pkg::tw_sin(tw_r);

  // addressing helpers
  logic [AW-1:0] rev, half, m_lo, ba, bb, bb_hi;
  logic [r2fft_pkg::StageW-1:0] lim;
  logic [4:0] twi;
  logic [AW-1:0] bfx;
  always_comb begin
    rev = '0;
    for (int i = 0; i < r2fft_pkg::LogPoints; i++)
      rev[r2fft_pkg::LogPoints-1-i] = cnt_r[i];
    half = AW'(1) << stg_r;
    bfx  = AW'(bf_r);
    m_lo = bfx & (half - AW'(1));
    bb_hi = (bfx >> stg_r) << (stg_r + 1);
    ba = bb_hi | m_lo;
    bb = ba | half;
    twi = 5'((m_lo << (AW - 1 - stg_r)) & AW'(31));
    lim = r2fft_pkg::StageW'(r2fft_pkg::LogPoints - 1);
  end

  logic emit_ok;
  assign emit_ok = !pend_r || out_ready;
  assign in_ready = (state_r == S_LOAD);

  // store requests
  always_comb begin
    req = '0;
    req.wdata_a.re = 23'($signed(in_sample[r2fft_pkg::SampleBits-1:0]));
    req.wdata_a.im = '0;
    case (state_r)
      S_LOAD: begin
        req.we_a = in_valid;
        req.addr_a = rev;
      end
      S_RD: begin
        req.addr_a = ba;
        req.addr_b = bb;
      end
      S_WR: begin
        req.we_a = 1'b1; req.we_b = 1'b1;
        req.addr_a = ea_r; req.addr_b = eb_r;
        req.wdata_a = ya; req.wdata_b = yb;
      end
      // read address held while an entry is pending
      S_EMIT: req.addr_a = pend_r ? pidx_r : cnt_r[AW-1:0];
      default: ;
    endcase
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD; cnt_r <= '0; stg_r <= '0; bf_r <= '0; pend_r <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && !(state_r == S_EMIT && pend_r)) out_valid <= 1'b0;
      case (state_r)
        S_LOAD: if (in_valid) begin
          if (cnt_r == (AW+1)'(r2fft_pkg::Points - 1)) begin
            cnt_r <= '0; state_r <= S_RD; stg_r <= '0; bf_r <= '0;
          end else cnt_r <= cnt_r + 1'b1;
        end
        S_RD: begin
          ea_r <= ba; eb_r <= bb; tw_r <= twi; state_r <= S_MUL;
        end
        S_MUL: state_r <= S_WR;
        S_WR: state_r <= S_GAP;
        S_GAP: begin
          if (bf_r == (AW-1)'(r2fft_pkg::Points/2 - 1)) begin
            bf_r <= '0;
            if (stg_r == lim) begin
              state_r <= S_EMIT; cnt_r <= '0; pend_r <= 1'b0;
            end else begin
              stg_r <= stg_r + 1'b1; state_r <= S_RD;
            end
          end else begin
            bf_r <= bf_r + 1'b1; state_r <= S_RD;
          end
        end
        S_EMIT: begin
          // read one entry whenever none is pending; it moves to the output once the slot is free
          if (pend_r && (!out_valid || out_ready)) begin
            out_valid <= 1'b1;
            out_bin_real <= rda.re;
            out_bin_imag <= rda.im;
            out_bin_index <= pidx_r;
            out_last_bin <= (pidx_r == AW'(r2fft_pkg::Points - 1));
            pend_r <= 1'b0;
            if (pidx_r == AW'(r2fft_pkg::Points - 1)) begin
              state_r <= S_LOAD; cnt_r <= '0;
            end
          end else if (!pend_r && (!out_valid || out_ready || emit_ok)) begin
            pend_r <= 1'b1; pidx_r <= cnt_r[AW-1:0]; cnt_r <= cnt_r + 1'b1;
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: hdl/r2fft_store.sv
`default_nettype none
module r2fft_store (
  input  wire logic               clk,
  input  wire r2fft_pkg::mem_req_t req,
  output r2fft_pkg::cplx_t        rdata_a,
  output r2fft_pkg::cplx_t        rdata_b
);

  r2fft_pkg::cplx_t mem [r2fft_pkg::Points];

  // two-port complex store, registered read
  always_ff @(posedge clk) begin
    if (req.we_a) mem[req.addr_a] <= req.wdata_a;
    if (req.we_b) mem[req.addr_b] <= req.wdata_b;
    rdata_a <= mem[req.addr_a];
    rdata_b <= mem[req.addr_b];
  end

endmodule
`default_nettype wire

FILE: hdl/r2fft_bfly.sv
`default_nettype none
module r2fft_bfly (
  input  wire logic                       clk,
  input  wire r2fft_pkg::cplx_t           a,
  input  wire r2fft_pkg::cplx_t           b,
  input  wire logic signed [15:0]         c,
  input  wire logic signed [15:0]         s,
  output r2fft_pkg::cplx_t                ya,
  output r2fft_pkg::cplx_t                yb
);

  logic signed [39:0] p_brc_r, p_bis_r, p_bic_r, p_brs_r;
  r2fft_pkg::cplx_t   a_r;
  logic signed [47:0] zr, zi;

  // products registered
  always_ff @(posedge clk) begin
    p_brc_r <= 40'(b.re * c);
    p_bis_r <= 40'(b.im * s);
    p_bic_r <= 40'(b.im * c);
    p_brs_r <= 40'(b.re * s);
    a_r     <= a;
  end

  // round, sum and saturate
  always_comb begin
    zr = 48'(r2fft_pkg::rnd15(p_brc_r)) + 48'(r2fft_pkg::rnd15(p_bis_r));
    zi = 48'(r2fft_pkg::rnd15(p_bic_r)) - 48'(r2fft_pkg::rnd15(p_brs_r));
    ya.re = r2fft_pkg::sat(48'(a_r.re) + zr);
    ya.im = r2fft_pkg::sat(48'(a_r.im) + zi);
    yb.re = r2fft_pkg::sat(48'(a_r.re) - zr);
    yb.im = r2fft_pkg::sat(48'(a_r.im) - zi);
  end

endmodule
`default_nettype wire
